### design/ortn_pkg.sv
// ortn_pkg: shared constants for the oriented triangle normal unit
// depends on nothing; used by the top level and its checker
package ortn_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_CENTROID_X = 2'd0,
    REG_CENTROID_Y = 2'd1,
    REG_CENTROID_Z = 2'd2
  } reg_index_t;

  localparam int REG_INDEX_BITS = 2;
  localparam int NORM_BITS      = 30;   // normalized magnitude width
  localparam int SQ_BITS        = 60;   // square of a normalized magnitude
  localparam int SUM_BITS       = 62;   // sum of three squares
  localparam int ROOT_BITS      = 31;   // floor sqrt of the sum
  localparam int SQRT_STEPS     = 32;   // one radicand bit pair per stage
  localparam int DIV_STEPS      = 31;   // one quotient bit per stage
  localparam int OUT_BITS       = 32;   // Q2.30 output width

  // stage where each part of the pipeline ends
  localparam int STG_SUM   = 8;
  localparam int STG_ROOT  = STG_SUM + SQRT_STEPS;    // 40
  localparam int STG_QUOT  = STG_ROOT + DIV_STEPS;    // 71
  localparam int STG_DOT   = STG_QUOT + 1;            // 72
  localparam int LATENCY   = STG_DOT + 1;

endpackage

### design/oriented_triangle_normal_unit.sv
// oriented_triangle_normal_unit: outward unit face normal of a triangle
// depends on ortn_pkg for constants and register indexes
//
// throughput: one triangle every cycle; busy is always low, results cannot be stalled
// the depth is set by the bit-serial square root (32 stages) and the three
//   restoring dividers (31 stages), one bit per stage
// reset (rst, synchronous): clears all valid bits and the centroid registers
module oriented_triangle_normal_unit #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         cfg_wr_en,
  input  logic [ortn_pkg::REG_INDEX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]        cfg_wr_data,
  input  logic signed [COORD_BITS-1:0] a_x,
  input  logic signed [COORD_BITS-1:0] a_y,
  input  logic signed [COORD_BITS-1:0] a_z,
  input  logic signed [COORD_BITS-1:0] b_x,
  input  logic signed [COORD_BITS-1:0] b_y,
  input  logic signed [COORD_BITS-1:0] b_z,
  input  logic signed [COORD_BITS-1:0] c_x,
  input  logic signed [COORD_BITS-1:0] c_y,
  input  logic signed [COORD_BITS-1:0] c_z,
  output logic                         done,
  output logic signed [ortn_pkg::OUT_BITS-1:0] normal_x,
  output logic signed [ortn_pkg::OUT_BITS-1:0] normal_y,
  output logic signed [ortn_pkg::OUT_BITS-1:0] normal_z,
  output logic                         degenerate,
  output logic                         zero_area
);

  // edge width, product width, cross product width, magnitude width
  localparam int E   = COORD_BITS + 1;
  localparam int P   = 2 * E;
  localparam int NW  = P + 1;
  localparam int MW  = P;
  localparam int LW  = $clog2(MW + 1);
  localparam int DW  = ortn_pkg::OUT_BITS + E;   // dot term width
  localparam int NB  = ortn_pkg::NORM_BITS;
  localparam int SB  = ortn_pkg::SUM_BITS;
  localparam int RB  = ortn_pkg::ROOT_BITS;
  localparam int SQS = ortn_pkg::SQRT_STEPS;
  localparam int DVS = ortn_pkg::DIV_STEPS;
  localparam int S_ROOT = ortn_pkg::STG_ROOT;
  localparam int S_DOT  = ortn_pkg::STG_DOT;
  localparam int LAT    = ortn_pkg::LATENCY;

  // the pipeline never stalls, so a word is taken whenever start is high
  assign busy = 1'b0;

  // centroid registers
  logic signed [COORD_BITS-1:0] centroid_x, centroid_y, centroid_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      centroid_x <= '0;
      centroid_y <= '0;
      centroid_z <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ortn_pkg::REG_CENTROID_X: centroid_x <= cfg_wr_data;
        ortn_pkg::REG_CENTROID_Y: centroid_y <= cfg_wr_data;
        ortn_pkg::REG_CENTROID_Z: centroid_z <= cfg_wr_data;
        default: ;  // writes past the last register are dropped
      endcase
    end
  end

  // valid bit of every stage
  logic [1:LAT] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {start, vld[1:LAT-1]};
    end
  end

  // payload carried alongside the arithmetic
  logic signed [E-1:0] d_line [1:S_DOT][0:2];    // a - centroid
  logic                degen_line [1:S_DOT];
  logic                zero_line  [5:S_DOT];
  logic [2:0]          neg_line   [4:S_DOT];
  logic [NB-1:0]       m_line     [6:S_ROOT][0:2];

  // stage 1: edges, offset from centroid, identical vertex check
  logic signed [E-1:0] e1 [0:2];
  logic signed [E-1:0] f1 [0:2];

  always_ff @(posedge clk) begin
    e1[0] <= E'(c_x) - E'(a_x);
    e1[1] <= E'(c_y) - E'(a_y);
    e1[2] <= E'(c_z) - E'(a_z);
    f1[0] <= E'(b_x) - E'(a_x);
    f1[1] <= E'(b_y) - E'(a_y);
    f1[2] <= E'(b_z) - E'(a_z);
    d_line[1][0] <= E'(a_x) - E'(centroid_x);
    d_line[1][1] <= E'(a_y) - E'(centroid_y);
    d_line[1][2] <= E'(a_z) - E'(centroid_z);
    degen_line[1] <= (a_x == b_x && a_y == b_y && a_z == b_z) ||
                     (b_x == c_x && b_y == c_y && b_z == c_z) ||
                     (a_x == c_x && a_y == c_y && a_z == c_z);
  end

  // stage 2: the six cross product terms
  logic signed [P-1:0] p2 [0:5];

  always_ff @(posedge clk) begin
    p2[0] <= P'(e1[1]) * P'(f1[2]);
    p2[1] <= P'(e1[2]) * P'(f1[1]);
    p2[2] <= P'(e1[2]) * P'(f1[0]);
    p2[3] <= P'(e1[0]) * P'(f1[2]);
    p2[4] <= P'(e1[0]) * P'(f1[1]);
    p2[5] <= P'(e1[1]) * P'(f1[0]);
  end

  // stage 3: cross product (c-a) x (b-a)
  logic signed [NW-1:0] n3 [0:2];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      n3[i] <= NW'(p2[2*i]) - NW'(p2[2*i+1]);
    end
  end

  // stage 4: sign and magnitude
  logic [MW-1:0] mg4 [0:2];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      neg_line[4][i] <= n3[i][NW-1];
      mg4[i]         <= n3[i][NW-1] ? MW'(-n3[i]) : MW'(n3[i]);
    end
  end

  // stage 5: bit length of the largest magnitude, zero cross product
  logic [MW-1:0] mg_or;
  logic [LW-1:0] len_c;
  logic [MW-1:0] mg5 [0:2];
  logic [LW-1:0] len5;

  always_comb begin
    mg_or = mg4[0] | mg4[1] | mg4[2];
    len_c = '0;
    for (int k = 0; k < MW; k++) begin
      if (mg_or[k]) len_c = LW'(k + 1);
    end
  end

  always_ff @(posedge clk) begin
    mg5          <= mg4;
    len5         <= len_c;
    zero_line[5] <= (mg_or == '0);
  end

  // stage 6: shift so the largest magnitude has exactly 30 bits
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (len5 > LW'(NB)) begin
        m_line[6][i] <= NB'(mg5[i] >> (len5 - LW'(NB)));
      end else begin
        m_line[6][i] <= NB'(mg5[i] << (LW'(NB) - len5));
      end
    end
  end

  // stage 7: squares
  logic [ortn_pkg::SQ_BITS-1:0] sq7 [0:2];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq7[i] <= ortn_pkg::SQ_BITS'(m_line[6][i]) * ortn_pkg::SQ_BITS'(m_line[6][i]);
    end
  end

  // stage 8: sum of squares, feeds the square root
  logic [SB-1:0] sq_rem  [0:SQS];
  logic [63:0]   sq_root [0:SQS];

  always_ff @(posedge clk) begin
    sq_rem[0]  <= SB'(sq7[0]) + SB'(sq7[1]) + SB'(sq7[2]);
    sq_root[0] <= '0;
  end

  // stages 9..40: digit-by-digit square root, one bit pair a stage
  for (genvar j = 0; j < SQS; j++) begin : g_sqrt
    localparam logic [63:0] BITV = 64'd1 << (2 * (SQS - 1 - j));
    logic [63:0] trial;
    assign trial = sq_root[j] + BITV;
    always_ff @(posedge clk) begin
      if ({2'b00, sq_rem[j]} >= trial) begin
        sq_rem[j+1]  <= sq_rem[j] - SB'(trial);
        sq_root[j+1] <= (sq_root[j] >> 1) + BITV;
      end else begin
        sq_rem[j+1]  <= sq_rem[j];
        sq_root[j+1] <= sq_root[j] >> 1;
      end
    end
  end

  // stages 41..71: rounded divide q = (m * 2^30 + r/2) / r, three lanes
  logic [SB-1:0] dv_rem [1:DVS][0:2];
  logic [RB-1:0] dv_q   [1:DVS][0:2];
  logic [RB-1:0] dv_r   [1:DVS];

  for (genvar j = 0; j < DVS; j++) begin : g_div
    localparam int K = DVS - 1 - j;
    logic [SB-1:0] rem_in [0:2];
    logic [RB-1:0] q_in   [0:2];
    logic [RB-1:0] r_in;
    logic [SB-1:0] dsr;
    if (j == 0) begin : g_first
      logic [RB-1:0] root;
      assign root = RB'(sq_root[SQS]);
      assign r_in = root;
      for (genvar i = 0; i < 3; i++) begin : g_ln
        assign rem_in[i] = (SB'(m_line[S_ROOT][i]) << NB) + SB'(root >> 1);
        assign q_in[i]   = '0;
      end
    end else begin : g_rest
      assign r_in = dv_r[j];
      for (genvar i = 0; i < 3; i++) begin : g_ln
        assign rem_in[i] = dv_rem[j][i];
        assign q_in[i]   = dv_q[j][i];
      end
    end
    assign dsr = SB'(r_in) << K;
    always_ff @(posedge clk) begin
      dv_r[j+1] <= r_in;
      for (int i = 0; i < 3; i++) begin
        if (rem_in[i] >= dsr) begin
          dv_rem[j+1][i] <= rem_in[i] - dsr;
          dv_q[j+1][i]   <= q_in[i] | (RB'(1) << K);
        end else begin
          dv_rem[j+1][i] <= rem_in[i];
          dv_q[j+1][i]   <= q_in[i];
        end
      end
    end
  end

  // stage 72: signed normal and its dot terms with (a - centroid)
  logic signed [ortn_pkg::OUT_BITS-1:0] v_c  [0:2];
  logic signed [ortn_pkg::OUT_BITS-1:0] v72  [0:2];
  logic signed [DW-1:0]                 dt72 [0:2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v_c[i] = neg_line[S_DOT-1][i] ? -ortn_pkg::OUT_BITS'(dv_q[DVS][i])
                                    :  ortn_pkg::OUT_BITS'(dv_q[DVS][i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      v72[i]  <= v_c[i];
      dt72[i] <= DW'(v_c[i]) * DW'(d_line[S_DOT-1][i]);
    end
  end

  // stage 73: flip toward the outside, special cases, output word
  logic signed [DW+1:0] dot;
  logic                 flip;

  assign dot  = (DW+2)'(dt72[0]) + (DW+2)'(dt72[1]) + (DW+2)'(dt72[2]);
  assign flip = dot[DW+1];

  always_ff @(posedge clk) begin
    if (degen_line[S_DOT]) begin
      normal_x   <= '0;
      normal_y   <= '0;
      normal_z   <= '0;
      degenerate <= 1'b1;
      zero_area  <= 1'b0;
    end else if (zero_line[S_DOT]) begin
      normal_x   <= '0;
      normal_y   <= '0;
      normal_z   <= '0;
      degenerate <= 1'b0;
      zero_area  <= 1'b1;
    end else begin
      normal_x   <= flip ? -v72[0] : v72[0];
      normal_y   <= flip ? -v72[1] : v72[1];
      normal_z   <= flip ? -v72[2] : v72[2];
      degenerate <= 1'b0;
      zero_area  <= 1'b0;
    end
  end

  assign done = vld[LAT];

  // payload delay lines, one register stage each
  for (genvar k = 2; k <= S_DOT; k++) begin : g_dly_d
    always_ff @(posedge clk) begin
      d_line[k]     <= d_line[k-1];
      degen_line[k] <= degen_line[k-1];
    end
  end

  for (genvar k = 6; k <= S_DOT; k++) begin : g_dly_z
    always_ff @(posedge clk) begin
      zero_line[k] <= zero_line[k-1];
    end
  end

  for (genvar k = 5; k <= S_DOT; k++) begin : g_dly_n
    always_ff @(posedge clk) begin
      neg_line[k] <= neg_line[k-1];
    end
  end

  for (genvar k = 7; k <= S_ROOT; k++) begin : g_dly_m
    always_ff @(posedge clk) begin
      m_line[k] <= m_line[k-1];
    end
  end

endmodule

### design/ortn_checker.sv
// ortn_checker: port-level checks of the oriented triangle normal unit
// depends on ortn_pkg; bound to the top level below
module ortn_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 start,
  input logic                                 busy,
  input logic                                 done,
  input logic signed [ortn_pkg::OUT_BITS-1:0] normal_x,
  input logic signed [ortn_pkg::OUT_BITS-1:0] normal_y,
  input logic signed [ortn_pkg::OUT_BITS-1:0] normal_z,
  input logic                                 degenerate,
  input logic                                 zero_area
);

  localparam logic signed [ortn_pkg::OUT_BITS-1:0] ONE = 32'sd1073741824;

  // a result only ever follows a word taken a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, ortn_pkg::LATENCY))
    else $error("result without a matching word");

  // the two flags never come together
  a_flags: assert property (@(posedge clk) disable iff (rst)
    done |-> !(degenerate && zero_area))
    else $error("both flags set");

  // flagged results carry a zero normal
  a_zero: assert property (@(posedge clk) disable iff (rst)
    done && (degenerate || zero_area) |->
      normal_x == 0 && normal_y == 0 && normal_z == 0)
    else $error("flagged result has a nonzero normal");

  // components of a unit normal stay within one
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> normal_x <= ONE && normal_x >= -ONE &&
             normal_y <= ONE && normal_y >= -ONE &&
             normal_z <= ONE && normal_z >= -ONE)
    else $error("normal component out of range");

endmodule

bind oriented_triangle_normal_unit ortn_checker u_ortn_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .normal_x   (normal_x),
  .normal_y   (normal_y),
  .normal_z   (normal_z),
  .degenerate (degenerate),
  .zero_area  (zero_area)
);
